>>> rtl/core/bs3_pkg.sv
// Shared constants and types for the edge-aware 3x3 box smoothing block.
package bs3_pkg;

	localparam int MAX_SIZE = 16;
	localparam int IDX_W    = $clog2(MAX_SIZE);
	localparam int SIZE_W   = 5;
	localparam int PIX_W    = 8;
	localparam int POS_W    = 4;
	localparam int SUM_W    = 12;
	localparam int NUM_CAND = 4;

	localparam logic [SUM_W-1:0] RECIP6 = 12'd2731;
	localparam logic [SUM_W-1:0] RECIP9 = 12'd3641;
	localparam int SHIFT6 = 14;
	localparam int SHIFT9 = 15;

	typedef enum logic [1:0] {
		DIV4,
		DIV6,
		DIV9
	} div_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		div_t             div;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             eof;
	} cand_t;

endpackage

>>> rtl/core/box_smooth_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box smoothing block.
// A result waits in the candidate stage, then the output register drives m_tvalid.
// One pixel is accepted per cycle while no result waits, or one waits and advances.
// The output register issues one result per cycle while m_tready holds high.
// Reset clears the position counters and sets the image size to 16.
// The line stores are not cleared; every entry read was written earlier in the frame.
module box_smooth_3x3_edge_aware (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bs3_pkg::SIZE_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // pixel
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // smoothed, out_row, out_col
	output logic                       m_tlast,   // last_in_run
	output logic                       m_tuser    // end_of_frame
);
	import bs3_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] size_eff;
	logic [POS_W-1:0]  last_idx;
	logic [IDX_W-1:0]  entry;
	logic [POS_W-1:0]  row_q;
	logic [POS_W-1:0]  col_q;
	logic              accept;
	logic              at_last_col;
	logic              at_last_row;
	logic [PIX_W-1:0]  tap_a;
	logic [PIX_W-1:0]  tap_b;
	logic [9:0]        s3_cur;
	logic [8:0]        s2_cur;
	logic [9:0]        s3_h1_q;
	logic [9:0]        s3_h2_q;
	logic [8:0]        s2_h1_q;
	logic [8:0]        s2_h2_q;
	cand_t             cand_new [NUM_CAND];
	logic [NUM_CAND-1:0] mask_new;
	cand_t             cand_s1 [NUM_CAND];
	logic [NUM_CAND-1:0] mask_q;
	logic [NUM_CAND-1:0] pick;
	logic [NUM_CAND-1:0] rest;
	logic              out_free;
	logic              advance;
	cand_t             sel;
	logic [23:0]       prod;
	logic [PIX_W-1:0]  quot;
	logic [PIX_W-1:0]  smooth_q;
	logic [POS_W-1:0]  orow_q;
	logic [POS_W-1:0]  ocol_q;
	logic              olast_q;
	logic              oeof_q;
	logic              ovalid_q;

	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			size_eff = SIZE_W'(2);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			size_eff = SIZE_W'(MAX_SIZE);
		end else begin
			size_eff = size_q;
		end
	end

	assign last_idx    = POS_W'(size_eff - SIZE_W'(1));
	assign entry       = IDX_W'(SIZE_W'(MAX_SIZE) - size_eff);
	assign at_last_col = (col_q == last_idx);
	assign at_last_row = (row_q == last_idx);
	assign accept      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(16);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	bs3_line u_line_a (
		.clk   (clk),
		.shift (accept),
		.entry (entry),
		.fresh (s_tdata),
		.tap   (tap_a)
	);

	bs3_line u_line_b (
		.clk   (clk),
		.shift (accept),
		.entry (entry),
		.fresh (tap_a),
		.tap   (tap_b)
	);

	assign s2_cur = 9'(s_tdata) + 9'(tap_a);
	assign s3_cur = 10'(s2_cur) + ((row_q >= POS_W'(2)) ? 10'(tap_b) : 10'd0);

	always_ff @(posedge clk) begin
		if (accept) begin
			s3_h1_q <= s3_cur;
			s3_h2_q <= s3_h1_q;
			s2_h1_q <= s2_cur;
			s2_h2_q <= s2_h1_q;
		end
	end

	always_comb begin
		logic rows3;
		logic cols3;
		rows3 = (row_q >= POS_W'(2));
		cols3 = (col_q >= POS_W'(2));

		cand_new[0].sum = SUM_W'(s3_cur) + SUM_W'(s3_h1_q)
			+ (cols3 ? SUM_W'(s3_h2_q) : '0);
		cand_new[0].div = (rows3 && cols3) ? DIV9 : ((rows3 || cols3) ? DIV6 : DIV4);
		cand_new[0].row = row_q - POS_W'(1);
		cand_new[0].col = col_q - POS_W'(1);
		cand_new[0].eof = 1'b0;

		cand_new[1].sum = SUM_W'(s3_cur) + SUM_W'(s3_h1_q);
		cand_new[1].div = rows3 ? DIV6 : DIV4;
		cand_new[1].row = row_q - POS_W'(1);
		cand_new[1].col = col_q;
		cand_new[1].eof = 1'b0;

		cand_new[2].sum = SUM_W'(s2_cur) + SUM_W'(s2_h1_q)
			+ (cols3 ? SUM_W'(s2_h2_q) : '0);
		cand_new[2].div = cols3 ? DIV6 : DIV4;
		cand_new[2].row = row_q;
		cand_new[2].col = col_q - POS_W'(1);
		cand_new[2].eof = 1'b0;

		cand_new[3].sum = SUM_W'(s2_cur) + SUM_W'(s2_h1_q);
		cand_new[3].div = DIV4;
		cand_new[3].row = row_q;
		cand_new[3].col = col_q;
		cand_new[3].eof = 1'b1;

		mask_new[0] = (row_q != '0) && (col_q != '0);
		mask_new[1] = (row_q != '0) && at_last_col;
		mask_new[2] = at_last_row && (col_q != '0);
		mask_new[3] = at_last_row && at_last_col;
	end

	assign out_free = !ovalid_q || m_tready;
	assign advance  = out_free && (mask_q != '0);
	assign pick     = mask_q & (~mask_q + NUM_CAND'(1));
	assign rest     = mask_q & ~pick;
	assign s_tready = (mask_q == '0) || (advance && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (accept) begin
			mask_q <= mask_new;
		end else if (advance) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_s1 <= cand_new;
		end
	end

	always_comb begin
		priority if (pick[0]) begin
			sel = cand_s1[0];
		end else if (pick[1]) begin
			sel = cand_s1[1];
		end else if (pick[2]) begin
			sel = cand_s1[2];
		end else begin
			sel = cand_s1[3];
		end
	end

	always_comb begin
		prod = 24'(sel.sum) * 24'((sel.div == DIV9) ? RECIP9 : RECIP6);
		unique case (sel.div)
			DIV9:    quot = PIX_W'(prod >> SHIFT9);
			DIV6:    quot = PIX_W'(prod >> SHIFT6);
			default: quot = PIX_W'(sel.sum >> 2);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			smooth_q <= quot;
			orow_q   <= sel.row;
			ocol_q   <= sel.col;
			olast_q  <= (rest == '0);
			oeof_q   <= sel.eof;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {ocol_q, orow_q, smooth_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = oeof_q;

`ifndef NO_ASSERTIONS
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("pending result did not reach the output register");

	a_ready_only_when_draining: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> ($countones(mask_q) <= 1))
		else $error("input accepted while several results are still pending");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("end of frame result is not the last of its transaction");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < size_eff) && ({1'b0, row_q} < size_eff))
		else $error("position counter outside the image");
`endif

endmodule

>>> rtl/core/bs3_cell.sv
// One pixel cell of a line delay chain.
module bs3_cell (
	input  logic                      clk,
	input  logic                      shift,
	input  logic                      inject,
	input  logic [bs3_pkg::PIX_W-1:0] fresh,
	input  logic [bs3_pkg::PIX_W-1:0] prev,
	output logic [bs3_pkg::PIX_W-1:0] q
);
	import bs3_pkg::*;

	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= inject ? fresh : prev;
		end
	end

	assign q = pix_q;

endmodule

>>> rtl/core/bs3_line.sv
// Line store built as a chain of pixel cells with a selectable entry point.
module bs3_line (
	input  logic                      clk,
	input  logic                      shift,
	input  logic [bs3_pkg::IDX_W-1:0] entry,
	input  logic [bs3_pkg::PIX_W-1:0] fresh,
	output logic [bs3_pkg::PIX_W-1:0] tap
);
	import bs3_pkg::*;

	logic [PIX_W-1:0] chain [MAX_SIZE];

	genvar i;
	generate
		for (i = 0; i < MAX_SIZE; i++) begin : g_cell
			logic [PIX_W-1:0] prev;
			if (i == 0) begin : g_head
				assign prev = fresh;
			end else begin : g_body
				assign prev = chain[i-1];
			end
			bs3_cell u_cell (
				.clk    (clk),
				.shift  (shift),
				.inject (entry == IDX_W'(i)),
				.fresh  (fresh),
				.prev   (prev),
				.q      (chain[i])
			);
		end
	endgenerate

	assign tap = chain[MAX_SIZE-1];

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the edge-aware 3x3 box smoothing block with a built-in predictor.
module tb;
	import bs3_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PIXELS = 80;

	typedef struct packed {
		logic [PIX_W-1:0] smoothed;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             eof;
	} smooth_px_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              cfg_we   = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	box_smooth_3x3_edge_aware u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	logic [PIX_W-1:0]  row_m2  [MAX_SIZE];
	logic [PIX_W-1:0]  row_m1  [MAX_SIZE];
	logic [PIX_W-1:0]  row_now [MAX_SIZE];
	logic [SIZE_W-1:0] size_reg = 5'd16;
	int                next_row = 0;
	int                next_col = 0;

	smooth_px_t expected_px[$];
	int         errors      = 0;
	int         pixels_sent = 0;
	bit         steady      = 1'b0;
	int         hold_cycles = 0;
	int         rx_gap      = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int active_side(logic [SIZE_W-1:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_SIZE)
			return MAX_SIZE;
		return int'(v);
	endfunction

	function automatic logic [PIX_W-1:0] neighbourhood_mean(int r, int c, int n, int cur);
		int               sum;
		int               cnt;
		int               x;
		int               y;
		logic [PIX_W-1:0] v;
		sum = 0;
		cnt = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			x = r + dr;
			if (x < 0 || x >= n || x > cur || x < cur - 2)
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				y = c + dc;
				if (y < 0 || y >= n)
					continue;
				if (x == cur)
					v = row_now[y];
				else if (x == cur - 1)
					v = row_m1[y];
				else
					v = row_m2[y];
				sum += v;
				cnt++;
			end
		end
		return (cnt == 0) ? '0 : PIX_W'(sum / cnt);
	endfunction

	function automatic smooth_px_t make_result(int r, int c, int n, int cur);
		smooth_px_t res;
		res.smoothed = neighbourhood_mean(r, c, n, cur);
		res.row      = POS_W'(r);
		res.col      = POS_W'(c);
		res.last     = 1'b0;
		res.eof      = (r == n - 1 && c == n - 1);
		return res;
	endfunction

	task automatic predict_pixel(logic [PIX_W-1:0] px);
		int         n;
		int         r;
		int         c;
		smooth_px_t run[$];
		n = active_side(size_reg);
		r = next_row;
		c = next_col;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		row_now[c] = px;
		if (r >= 1 && c >= 1)
			run.push_back(make_result(r - 1, c - 1, n, r));
		if (r >= 1 && c == n - 1)
			run.push_back(make_result(r - 1, c, n, r));
		if (r == n - 1 && c >= 1)
			run.push_back(make_result(r, c - 1, n, r));
		if (r == n - 1 && c == n - 1)
			run.push_back(make_result(r, c, n, r));
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			expected_px.push_back(run[i]);
		if (c == n - 1) begin
			row_m2   = row_m1;
			row_m1   = row_now;
			next_col = 0;
			next_row = (r == n - 1) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Called and returns at a falling edge.
	task automatic send_pixel(logic [PIX_W-1:0] px);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_pixel(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_px.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The block must be idle; a write restarts the frame.
	task automatic write_size(logic [SIZE_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		size_reg = v;
		next_row = 0;
		next_col = 0;
		@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		smooth_px_t got;
		smooth_px_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tlast, m_tuser};
			if (expected_px.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: value %0d row %0d col %0d last %0b eof %0b",
						got.smoothed, got.row, got.col, got.last, got.eof);
			end else begin
				want = expected_px.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("mismatch: expected value %0d row %0d col %0d last %0b eof %0b",
							want.smoothed, want.row, want.col, want.last, want.eof);
						$display("          got value %0d row %0d col %0d last %0b eof %0b",
							got.smoothed, got.row, got.col, got.last, got.eof);
					end
				end
			end
			rx_gap = steady ? 0 : $urandom_range(0, 4);
		end
	end

	// Runs at the reset size and stops mid-frame, so the next write also restarts a frame.
	task automatic test_reset_size();
		for (int i = 0; i < 18; i++)
			send_pixel((i % 3 == 0) ? 8'd255 : rand_pixel());
		wait_drained();
	endtask

	task automatic test_smallest_frame();
		write_size(5'd0);
		repeat (4) send_pixel(8'd255);
		wait_drained();
	endtask

	task automatic test_inner_window();
		logic [PIX_W-1:0] pattern [9];
		pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};
		write_size(5'd3);
		foreach (pattern[i])
			send_pixel(pattern[i]);
		wait_drained();
	endtask

	task automatic test_output_stall();
		write_size(5'd5);
		steady = 1'b1;
		@(posedge clk);
		hold_cycles = 80;
		@(negedge clk);
		repeat (25) send_pixel(rand_pixel());
		wait_drained();
		steady = 1'b0;
	endtask

	task automatic test_random_frames();
		logic [SIZE_W-1:0] v;
		int                n;
		int                cnt;
		int                goal;
		goal = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < goal) begin
			case ($urandom_range(0, 9))
				0: v = SIZE_W'($urandom_range(0, 1));
				1: v = SIZE_W'($urandom_range(17, 31));
				default: v = SIZE_W'($urandom_range(2, 7));
			endcase
			write_size(v);
			n = active_side(v);
			if (n == MAX_SIZE) begin
				cnt = $urandom_range(20, 48);
			end else begin
				cnt = n * n;
				if ($urandom_range(0, 3) == 0)
					cnt += $urandom_range(1, n * n - 1);
			end
			steady = ($urandom_range(0, 3) == 0);
			repeat (cnt) begin
				send_pixel(rand_pixel());
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
			wait_drained();
		end
		steady = 1'b0;
	endtask

	task automatic test_largest_frame();
		write_size(5'd31);
		repeat (40) send_pixel(rand_pixel());
		wait_drained();
		write_size(5'd16);
		repeat (20) send_pixel(rand_pixel());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_size();
		test_smallest_frame();
		test_inner_window();
		test_output_stall();
		test_random_frames();
		test_largest_frame();
		wait_drained();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
